// ----- rtl/erhs_pkg.sv -----
// Shared types and constants of the echo reply host statistics block.
package erhs_pkg;

    localparam int HOST_AW    = 8;
    localparam int HOST_DEPTH = 256;
    localparam int CNT_W      = 5;
    localparam int RTT_W      = 24;
    localparam int SUM_W      = 30;
    localparam int LOSS_W     = 7;

    localparam logic [7:0]       MAX_PROBES   = 8'd30;
    localparam logic [CNT_W-1:0] RECV_LIMIT   = 5'd31;
    localparam logic [SUM_W-1:0] SUM_LIMIT    = 30'h3FFF_FFFF;
    localparam logic [11:0]      PERCENT      = 12'd100;
    localparam logic [7:0]       ECHO_REPLY   = 8'd0;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TYPE  = 2'd1;
    localparam logic [1:0] ST_IDENT = 2'd2;
    localparam logic [1:0] ST_SEQ   = 2'd3;

    localparam logic [1:0] COL_GREEN  = 2'd0;
    localparam logic [1:0] COL_YELLOW = 2'd1;
    localparam logic [1:0] COL_RED    = 2'd2;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_SENT   = 3'd1,
        OP_REPLY  = 3'd2,
        OP_REPORT = 3'd3,
        OP_FAIL   = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        K_NOP,
        K_LOAD,
        K_SENT,
        K_REPLY,
        K_REJECT,
        K_REPORT,
        K_FAIL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [HOST_AW-1:0] host;
        logic [1:0]         status;
        logic [CNT_W-1:0]   cnt;
        logic [CNT_W-1:0]   yel;
        logic [CNT_W-1:0]   red;
        logic [RTT_W-1:0]   rtt;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] target;
        logic [CNT_W-1:0] yel;
        logic [CNT_W-1:0] red;
        logic [CNT_W-1:0] sent;
        logic [CNT_W-1:0] recv;
        logic             fin;
        logic [RTT_W-1:0] min_rtt;
        logic [RTT_W-1:0] max_rtt;
        logic [SUM_W-1:0] sum;
    } entry_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              completed;
        logic [1:0]        color;
        logic [LOSS_W-1:0] loss;
        logic [RTT_W-1:0]  min_us;
        logic [RTT_W-1:0]  avg_us;
        logic [RTT_W-1:0]  max_us;
        logic [CNT_W-1:0]  sent;
        logic [CNT_W-1:0]  recv;
    } result_t;

    typedef struct packed {
        logic   valid;
        cmd_t   cmd;
    } queue_head_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOSS,
        S_AVG,
        S_DONE
    } back_state_t;

endpackage

// ----- rtl/erhs_if.sv -----
// Request and response channel interfaces of the host statistics block.
interface erhs_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  host_index;
    logic [7:0]  probe_count;
    logic [7:0]  yellow_misses;
    logic [7:0]  red_misses;
    logic [7:0]  message_type;
    logic [15:0] reply_identifier;
    logic [15:0] reply_sequence;
    logic [23:0] round_trip_us;

    modport source (output valid, opcode, host_index, probe_count, yellow_misses,
                    red_misses, message_type, reply_identifier, reply_sequence,
                    round_trip_us, input ready);
    modport sink (input valid, opcode, host_index, probe_count, yellow_misses,
                  red_misses, message_type, reply_identifier, reply_sequence,
                  round_trip_us, output ready);
endinterface

interface erhs_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        host_completed;
    logic [1:0]  color;
    logic [6:0]  loss_percent;
    logic [23:0] min_us;
    logic [23:0] avg_us;
    logic [23:0] max_us;
    logic [4:0]  sent_total;
    logic [4:0]  received_total;

    modport source (output valid, status, host_completed, color, loss_percent,
                    min_us, avg_us, max_us, sent_total, received_total, input ready);
    modport sink (input valid, status, host_completed, color, loss_percent,
                  min_us, avg_us, max_us, sent_total, received_total, output ready);
endinterface

// ----- rtl/erhs_front.sv -----
// Front end: accepts request beats, classifies them and queues commands.
module erhs_front (
    input  logic            clk,
    input  logic            rst_n,
    erhs_req_if.sink        req,
    input  logic [15:0]     ident,
    input  logic [8:0]      host_count,
    input  logic            pop,
    output erhs_pkg::queue_head_t head
);
    import erhs_pkg::*;

    cmd_t       cmd;
    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic [7:0] cnt8, yel8, red8;
    logic       push;

    always_comb
    begin
        cnt8 = req.probe_count;
        if (cnt8 < 8'd1)
        begin
            cnt8 = 8'd1;
        end
        if (cnt8 > MAX_PROBES)
        begin
            cnt8 = MAX_PROBES;
        end
        yel8 = (req.yellow_misses > cnt8) ? cnt8 : req.yellow_misses;
        red8 = (req.red_misses > cnt8) ? cnt8 : req.red_misses;
        if (red8 < yel8)
        begin
            red8 = yel8;
        end
    end

    always_comb
    begin
        cmd.host   = req.host_index;
        cmd.status = ST_OK;
        cmd.cnt    = cnt8[CNT_W-1:0];
        cmd.yel    = yel8[CNT_W-1:0];
        cmd.red    = red8[CNT_W-1:0];
        cmd.rtt    = req.round_trip_us;
        case (opcode_t'(req.opcode))
            OP_LOAD:   cmd.kind = K_LOAD;
            OP_SENT:   cmd.kind = K_SENT;
            OP_REPORT: cmd.kind = K_REPORT;
            OP_FAIL:   cmd.kind = K_FAIL;
            OP_REPLY:
            begin
                cmd.kind = K_REJECT;
                cmd.host = req.reply_sequence[HOST_AW-1:0];
                if (req.message_type != ECHO_REPLY)
                begin
                    cmd.status = ST_TYPE;
                end
                else if (req.reply_identifier != ident)
                begin
                    cmd.status = ST_IDENT;
                end
                else if (req.reply_sequence >= {7'd0, host_count}
                         || req.reply_sequence >= 16'(HOST_DEPTH))
                begin
                    cmd.status = ST_SEQ;
                end
                else
                begin
                    cmd.kind = K_REPLY;
                end
            end
            default:   cmd.kind = K_NOP;
        endcase
    end

    assign req.ready  = (count_reg != 2'd2);
    assign push       = req.valid && req.ready;
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

// ----- rtl/erhs_div.sv -----
// Restoring divider, one quotient bit per cycle.
module erhs_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [erhs_pkg::SUM_W-1:0] dividend,
    input  logic [erhs_pkg::CNT_W-1:0] divisor,
    output logic                      done,
    output logic [erhs_pkg::SUM_W-1:0] quotient
);
    import erhs_pkg::*;

    logic [SUM_W-1:0] q_reg, q_next;
    logic [CNT_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] div_reg, div_next;
    logic [4:0]       step_reg, step_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W:0]   shifted;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[CNT_W-1:0], q_reg[SUM_W-1]};
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            div_next  = divisor;
            step_next = 5'(SUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = shifted - {1'b0, div_reg};
                q_next   = {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 5'd1;
            if (step_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- rtl/erhs_back.sv -----
// Back end: host table, read-modify-write of entries and report arithmetic.
module erhs_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  erhs_pkg::queue_head_t  head,
    output logic                   pop,
    erhs_rsp_if.source             rsp
);
    import erhs_pkg::*;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg;
    entry_t      mem [HOST_DEPTH];
    entry_t      rd_reg;
    entry_t      wdata;
    result_t     res_reg, res_next;
    result_t     out_reg;
    logic        out_valid_reg, out_valid_next;
    logic        mem_we, out_load, div_start, div_done;
    logic [SUM_W-1:0] div_dividend, div_q;
    logic [CNT_W-1:0] div_divisor;
    logic [CNT_W-1:0] recv_new;
    logic [SUM_W:0]   sum_wide;
    logic signed [CNT_W:0] missed;

    always_comb
    begin
        recv_new = (rd_reg.recv < RECV_LIMIT) ? rd_reg.recv + 5'd1 : rd_reg.recv;
        sum_wide = {1'b0, rd_reg.sum} + {7'd0, cmd_reg.rtt};
        missed   = $signed({1'b0, rd_reg.sent}) - $signed({1'b0, rd_reg.recv});
        wdata    = rd_reg;
        res_next = res_reg;
        if (state_reg == S_EXEC)
        begin
            res_next        = '0;
            res_next.status = cmd_reg.status;
        end
        case (cmd_reg.kind)
            K_LOAD:
            begin
                wdata        = '0;
                wdata.target = cmd_reg.cnt;
                wdata.yel    = cmd_reg.yel;
                wdata.red    = cmd_reg.red;
            end
            K_SENT:
            begin
                if (rd_reg.sent < rd_reg.target)
                begin
                    wdata.sent = rd_reg.sent + 5'd1;
                end
            end
            K_FAIL:
            begin
                wdata.fin = 1'b1;
            end
            K_REPLY:
            begin
                wdata.recv = recv_new;
                if (recv_new == 5'd1)
                begin
                    wdata.min_rtt = cmd_reg.rtt;
                    wdata.max_rtt = cmd_reg.rtt;
                end
                else
                begin
                    if (cmd_reg.rtt > rd_reg.max_rtt)
                    begin
                        wdata.max_rtt = cmd_reg.rtt;
                    end
                    if (cmd_reg.rtt < rd_reg.min_rtt)
                    begin
                        wdata.min_rtt = cmd_reg.rtt;
                    end
                end
                wdata.sum = (sum_wide > {1'b0, SUM_LIMIT}) ? SUM_LIMIT
                                                            : sum_wide[SUM_W-1:0];
                if (recv_new == rd_reg.target)
                begin
                    wdata.fin = 1'b1;
                    if (state_reg == S_EXEC)
                    begin
                        res_next.completed = 1'b1;
                    end
                end
            end
            K_REPORT:
            begin
                wdata.sent    = '0;
                wdata.recv    = '0;
                wdata.fin     = 1'b0;
                wdata.min_rtt = '0;
                wdata.max_rtt = '0;
                wdata.sum     = '0;
                if (state_reg == S_EXEC)
                begin
                    if (missed >= $signed({1'b0, rd_reg.red}))
                    begin
                        res_next.color = COL_RED;
                    end
                    else if (missed >= $signed({1'b0, rd_reg.yel}))
                    begin
                        res_next.color = COL_YELLOW;
                    end
                    else
                    begin
                        res_next.color = COL_GREEN;
                    end
                    res_next.min_us = rd_reg.min_rtt;
                    res_next.max_us = rd_reg.max_rtt;
                    res_next.sent   = rd_reg.sent;
                    res_next.recv   = rd_reg.recv;
                end
            end
            default:
            begin
                wdata = rd_reg;
            end
        endcase
        if (state_reg == S_LOSS && div_done)
        begin
            res_next.loss = (missed > 0) ? div_q[LOSS_W-1:0] : '0;
        end
        if (state_reg == S_AVG && div_done)
        begin
            res_next.avg_us = (div_q > SUM_W'(24'hFF_FFFF)) ? 24'hFF_FFFF
                                                            : div_q[RTT_W-1:0];
        end
    end

    always_comb
    begin
        if (state_reg == S_EXEC)
        begin
            div_dividend = (missed > 0)
                           ? SUM_W'(12'(missed[CNT_W-1:0]) * PERCENT) : '0;
            div_divisor  = (rd_reg.sent == '0) ? 5'd1 : rd_reg.sent;
        end
        else
        begin
            div_dividend = rd_reg.sum;
            div_divisor  = (rd_reg.recv == '0) ? 5'd1 : rd_reg.recv;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (head.valid) state_next = S_EXEC;
            S_EXEC: state_next = (cmd_reg.kind == K_REPORT) ? S_LOSS : S_DONE;
            S_LOSS: if (div_done) state_next = S_AVG;
            S_AVG:  if (div_done) state_next = S_DONE;
            S_DONE: if (!out_valid_reg || rsp.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        mem_we    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE: pop = head.valid;
            S_EXEC:
            begin
                mem_we    = (cmd_reg.kind != K_NOP) && (cmd_reg.kind != K_REJECT);
                div_start = (cmd_reg.kind == K_REPORT);
            end
            S_LOSS: div_start = div_done;
            S_AVG:  ;
            S_DONE: out_load = !out_valid_reg || rsp.ready;
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    erhs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head.cmd;
            rd_reg  <= mem[head.cmd.host];
        end
        if (mem_we)
        begin
            mem[cmd_reg.host] <= wdata;
        end
        res_reg <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.host_completed = out_reg.completed;
    assign rsp.color          = out_reg.color;
    assign rsp.loss_percent   = out_reg.loss;
    assign rsp.min_us         = out_reg.min_us;
    assign rsp.avg_us         = out_reg.avg_us;
    assign rsp.max_us         = out_reg.max_us;
    assign rsp.sent_total     = out_reg.sent;
    assign rsp.received_total = out_reg.recv;

endmodule

// ----- rtl/echo_reply_host_statistics_top.sv -----
// Top level of the echo reply host statistics block.
//
// Requests arrive on req as valid/ready beats; each gives exactly one response
// beat on rsp, in order. The front end classifies a request in the cycle it is
// accepted and holds up to two commands in a queue, so requests keep being
// taken while the back end works or while rsp is stalled.
// The back end reads the host entry from a 256-entry table into a register,
// writes it back updated and hands the response to an output register; load,
// sent, reply and fail commands pass through the idle, execute and done states.
// A report runs two divisions in turn on a shared bit-serial divider, for the
// loss percentage and the average. Configuration is written on cfg_we with
// cfg_index 0 for the echo identifier and 1 for the host count; the user must
// write it only while the block is idle, which the block does not enforce.
// Reset empties the queue and output register and clears both configuration
// registers; table entries hold nothing defined until a host is loaded.
// When rsp is stalled the back end waits with its finished response and the
// queue fills, after which req.ready falls.
module echo_reply_host_statistics_top (
    input  logic        clk,
    input  logic        rst_n,
    erhs_req_if.sink    req,
    erhs_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import erhs_pkg::*;

    localparam logic CFG_IDENT = 1'b0;
    localparam logic CFG_HOSTS = 1'b1;

    logic [15:0] ident_reg;
    logic [8:0]  host_count_reg;
    logic        pop;
    queue_head_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg      <= '0;
            host_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDENT: ident_reg      <= cfg_data;
                CFG_HOSTS: host_count_reg <= cfg_data[8:0];
                default:   ;
            endcase
        end
    end

    erhs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .ident      (ident_reg),
        .host_count (host_count_reg),
        .pop        (pop),
        .head       (head)
    );

    erhs_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule
